// ===== src/hbid_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers of the hierarchical bitmap ID allocator.
// Used by every module in src; no dependencies.
package hbid_pkg;

    localparam int FANOUT_BITS = 5;
    localparam int LEVELS      = 2;
    localparam int FAN         = 1 << FANOUT_BITS;
    localparam int ID_BITS     = FANOUT_BITS * LEVELS;
    localparam int ID_SPACE    = 1 << ID_BITS;
    localparam int NUM_LEAVES  = ID_SPACE >> FANOUT_BITS;
    localparam int LEAF_W      = ID_BITS - FANOUT_BITS;
    localparam int LVL_W       = $clog2(LEVELS + 1);
    localparam int VALUE_WIDTH = 64;
    localparam int DATA_W      = 64;

    typedef logic [FAN-1:0] fan_map_t;

    typedef enum logic [2:0] {
        CMD_ALLOC      = 3'd0,
        CMD_ALLOC_FROM = 3'd1,
        CMD_FREE       = 3'd2,
        CMD_LOOKUP     = 3'd3,
        CMD_REPLACE    = 3'd4,
        CMD_CLEAR      = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_SPACE  = 2'd1,
        ST_NOT_ALLOC = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]        command;
        logic [9:0]        id;
        logic [DATA_W-1:0] value;
    } in_word_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [9:0]        result_id;
        logic [DATA_W-1:0] result_value;
    } out_word_t;

    // leaf bitmap store access for one cycle
    typedef struct packed {
        logic [LEAF_W-1:0] rd_addr;
        logic              wr_en;
        logic [LEAF_W-1:0] wr_addr;
        fan_map_t          wr_data;
        logic              clear;
    } leaf_req_t;

    // index of the lowest set bit, zero when none
    function automatic logic [FANOUT_BITS-1:0] lowest_set(input fan_map_t m);
        logic [FANOUT_BITS-1:0] idx;
        idx = '0;
        for (int i = FAN - 1; i >= 0; i--) begin
            if (m[i]) begin
                idx = FANOUT_BITS'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ===== src/hbid_leaf_store.sv =====
`timescale 1ns / 1ps
// Leaf free-bitmap memory with per-row valid bits; an unwritten row reads all free.
// Depends on hbid_pkg.
module hbid_leaf_store (
    input  logic                aclk,
    input  logic                aresetn,
    input  hbid_pkg::leaf_req_t req,
    output hbid_pkg::fan_map_t  rd_data
);

    hbid_pkg::fan_map_t                   mem [hbid_pkg::NUM_LEAVES];
    logic [hbid_pkg::NUM_LEAVES-1:0]      vld_reg;
    hbid_pkg::fan_map_t                   rd_reg;
    logic                                 rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_reg <= mem[req.rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= vld_reg[req.rd_addr];
            if (req.clear) begin
                vld_reg <= '0;
            end else if (req.wr_en) begin
                vld_reg[req.wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_reg : '1;

endmodule

// ===== src/hbid_value_store.sv =====
`timescale 1ns / 1ps
// Value memory, one entry per ID, one write and one registered read port.
// Depends on hbid_pkg.
module hbid_value_store #(
    parameter int VALUE_WIDTH = hbid_pkg::VALUE_WIDTH
) (
    input  logic                         aclk,
    input  logic                         wr_en,
    input  logic [hbid_pkg::ID_BITS-1:0] wr_addr,
    input  logic [VALUE_WIDTH-1:0]       wr_data,
    input  logic [hbid_pkg::ID_BITS-1:0] rd_addr,
    output logic [VALUE_WIDTH-1:0]       rd_data
);

    logic [VALUE_WIDTH-1:0] mem [hbid_pkg::ID_SPACE];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/hierarchical_bitmap_id_allocator.sv =====
`timescale 1ns / 1ps
// ID allocator over 1024 IDs with a stored value per ID. The free state lives in a
// 32-bit summary register (one bit per leaf with a free ID) and a 32 x 32 leaf
// bitmap memory; values live in a 1024-entry memory. One command is in flight at
// a time: accept and memory read, one leaf inspection, then write-back and
// result; when the start leaf has no free ID the summary picks a second leaf to
// read before the write-back. The value memory is not cleared by CLEAR:
// a value is only read back for an allocated ID, which was written on allocation.
// Depends on hbid_pkg, hbid_leaf_store and hbid_value_store.
module hierarchical_bitmap_id_allocator #(
    parameter int VALUE_WIDTH = hbid_pkg::VALUE_WIDTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hbid_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output hbid_pkg::out_word_t m_data
);

    localparam int FB = hbid_pkg::FANOUT_BITS;
    localparam int LW = hbid_pkg::LEAF_W;
    localparam int IW = hbid_pkg::ID_BITS;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOOK = 4'b0010,
        S_NEXT = 4'b0100,
        S_WB   = 4'b1000
    } state_t;

    state_t                         state_reg, state_next;
    logic [2:0]                     cmd_reg;
    logic [IW-1:0]                  id_reg;
    logic [VALUE_WIDTH-1:0]         val_reg;
    hbid_pkg::fan_map_t             top_reg, top_next;
    logic [hbid_pkg::LVL_W-1:0]     lvl_reg, lvl_next;
    logic [LW-1:0]                  leaf_reg, leaf_next;
    logic [FB-1:0]                  bit_reg, bit_next;
    hbid_pkg::fan_map_t             wdata_reg, wdata_next;
    logic                           wr_leaf_reg, wr_leaf_next;
    logic                           wr_val_reg, wr_val_next;
    logic [1:0]                     status_reg, status_next;
    logic [VALUE_WIDTH-1:0]         rval_reg, rval_next;
    logic                           m_valid_reg, m_valid_next;
    hbid_pkg::out_word_t            m_data_reg, m_data_next;

    hbid_pkg::leaf_req_t            leaf_req;
    hbid_pkg::fan_map_t             leaf_data;
    logic [VALUE_WIDTH-1:0]         vrd_data;
    logic                           out_free;
    logic                           is_alloc;
    logic                           id_free;
    hbid_pkg::fan_map_t             bit_mask, avail, later;
    logic [IW-1:0]                  tgt_id;
    logic                           wb_fire;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign is_alloc = (cmd_reg == hbid_pkg::CMD_ALLOC) || (cmd_reg == hbid_pkg::CMD_ALLOC_FROM);
    assign bit_mask = hbid_pkg::fan_map_t'(1) << id_reg[FB-1:0];
    assign id_free  = |(leaf_data & bit_mask);
    assign avail    = (cmd_reg == hbid_pkg::CMD_ALLOC_FROM)
                    ? (leaf_data & ('1 << id_reg[FB-1:0])) : leaf_data;
    // summary bits of leaves above the one just read
    assign later    = top_reg & ~('1 >> (LW'(hbid_pkg::FAN - 1) - leaf_reg));
    assign tgt_id   = is_alloc ? {leaf_reg, bit_reg} : id_reg;
    assign wb_fire  = (state_reg == S_WB) && out_free;

    always_comb begin
        leaf_req.rd_addr = (state_reg == S_IDLE)
                         ? ((s_data.command == hbid_pkg::CMD_ALLOC) ? '0 : s_data.id[IW-1:FB])
                         : leaf_next;
        leaf_req.wr_en   = wb_fire && wr_leaf_reg;
        leaf_req.wr_addr = leaf_reg;
        leaf_req.wr_data = wdata_reg;
        leaf_req.clear   = wb_fire && (cmd_reg == hbid_pkg::CMD_CLEAR);
    end

    hbid_leaf_store u_leaf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (leaf_req),
        .rd_data (leaf_data)
    );

    hbid_value_store #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_value (
        .aclk    (aclk),
        .wr_en   (wb_fire && wr_val_reg),
        .wr_addr (tgt_id),
        .wr_data ((cmd_reg == hbid_pkg::CMD_FREE) ? '0 : val_reg),
        .rd_addr (s_data.id[IW-1:0]),
        .rd_data (vrd_data)
    );

    always_comb begin
        state_next   = state_reg;
        top_next     = top_reg;
        lvl_next     = lvl_reg;
        leaf_next    = leaf_reg;
        bit_next     = bit_reg;
        wdata_next   = wdata_reg;
        wr_leaf_next = wr_leaf_reg;
        wr_val_next  = wr_val_reg;
        status_next  = status_reg;
        rval_next    = rval_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    leaf_next  = (s_data.command == hbid_pkg::CMD_ALLOC)
                               ? '0 : s_data.id[IW-1:FB];
                    state_next = S_LOOK;
                end
            end
            S_LOOK: begin
                wr_leaf_next = 1'b0;
                wr_val_next  = 1'b0;
                status_next  = hbid_pkg::ST_OK;
                rval_next    = '0;
                state_next   = S_WB;
                case (cmd_reg)
                    hbid_pkg::CMD_ALLOC, hbid_pkg::CMD_ALLOC_FROM: begin
                        if (|avail) begin
                            bit_next     = hbid_pkg::lowest_set(avail);
                            wdata_next   = leaf_data
                                         & ~(hbid_pkg::fan_map_t'(1) << hbid_pkg::lowest_set(avail));
                            wr_leaf_next = 1'b1;
                            wr_val_next  = 1'b1;
                        end else if (|later) begin
                            // summary bit set: that leaf surely has a free ID
                            leaf_next  = hbid_pkg::lowest_set(later);
                            state_next = S_NEXT;
                        end else begin
                            status_next = hbid_pkg::ST_NO_SPACE;
                        end
                    end
                    hbid_pkg::CMD_FREE: begin
                        if (id_free) begin
                            status_next = hbid_pkg::ST_NOT_ALLOC;
                        end else begin
                            wdata_next   = leaf_data | bit_mask;
                            wr_leaf_next = 1'b1;
                            wr_val_next  = 1'b1;
                        end
                    end
                    hbid_pkg::CMD_LOOKUP: begin
                        if (!id_free) begin
                            rval_next = vrd_data;
                        end
                    end
                    hbid_pkg::CMD_REPLACE: begin
                        if (id_free) begin
                            status_next = hbid_pkg::ST_NOT_ALLOC;
                        end else begin
                            rval_next   = vrd_data;
                            wr_val_next = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_NEXT: begin
                bit_next     = hbid_pkg::lowest_set(leaf_data);
                wdata_next   = leaf_data
                             & ~(hbid_pkg::fan_map_t'(1) << hbid_pkg::lowest_set(leaf_data));
                wr_leaf_next = 1'b1;
                wr_val_next  = 1'b1;
                state_next   = S_WB;
            end
            S_WB: begin
                if (out_free) begin
                    if (cmd_reg == hbid_pkg::CMD_CLEAR) begin
                        top_next = '1;
                        lvl_next = '0;
                    end else if (wr_leaf_reg) begin
                        top_next[leaf_reg] = |wdata_reg;
                    end
                    if (is_alloc && wr_leaf_reg) begin
                        if (leaf_reg != '0 && lvl_reg < hbid_pkg::LVL_W'(hbid_pkg::LEVELS)) begin
                            lvl_next = hbid_pkg::LVL_W'(hbid_pkg::LEVELS);
                        end else if (lvl_reg == '0) begin
                            lvl_next = hbid_pkg::LVL_W'(1);
                        end
                    end
                    m_valid_next             = 1'b1;
                    m_data_next.status       = status_reg;
                    m_data_next.result_id    = (is_alloc && wr_leaf_reg) ? 10'(tgt_id) : '0;
                    m_data_next.result_value = hbid_pkg::DATA_W'(rval_reg);
                    state_next               = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            top_reg     <= '1;
            lvl_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            top_reg     <= top_next;
            lvl_reg     <= lvl_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg <= s_data.command;
            id_reg  <= s_data.id[IW-1:0];
            val_reg <= s_data.value[VALUE_WIDTH-1:0];
        end
        leaf_reg    <= leaf_next;
        bit_reg     <= bit_next;
        wdata_reg   <= wdata_next;
        wr_leaf_reg <= wr_leaf_next;
        wr_val_reg  <= wr_val_next;
        status_reg  <= status_next;
        rval_reg    <= rval_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_nospace_zero_id : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == hbid_pkg::ST_NO_SPACE |-> m_data.result_id == '0)
        else $error("no-space result carries an ID");

    a_clear_top : assert property (@(posedge aclk) disable iff (!aresetn)
        wb_fire && cmd_reg == hbid_pkg::CMD_CLEAR |=> top_reg == '1)
        else $error("summary not full after clear");

    a_next_has_free : assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_NEXT |-> leaf_data != '0)
        else $error("summary pointed at a full leaf");

    a_idle_ready : assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == S_LOOK && !s_ready)
        else $error("command accepted without starting the look-up");

endmodule

// ===== sim/hierarchical_bitmap_id_allocator_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the ID allocator: table-driven directed words, a fill run, then random traffic.
// Depends on hbid_pkg and hierarchical_bitmap_id_allocator.
module hierarchical_bitmap_id_allocator_test;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_FILL         = 160;
    localparam int N_RANDOM       = 420;

    typedef struct packed {
        logic [2:0]  command;
        logic [9:0]  id;
        logic [63:0] value;
        logic        known;
        logic [1:0]  status;
        logic [9:0]  result_id;
        logic [63:0] result_value;
    } stim_row_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    hbid_pkg::in_word_t  s_data;
    logic                m_valid;
    logic                m_ready;
    hbid_pkg::out_word_t m_data;

    // bench copy of the allocator state
    logic [31:0] free_map [32];
    logic [63:0] id_value [1024];

    hbid_pkg::out_word_t pending_results [$];
    int                  mismatch_count;
    int                  result_count;
    int                  idle_cycles;
    int                  ops_seen [8];

    hierarchical_bitmap_id_allocator u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic void clear_allocator();
        for (int i = 0; i < 32; i++) begin
            free_map[i] = '1;
        end
        for (int i = 0; i < 1024; i++) begin
            id_value[i] = '0;
        end
    endfunction

    function automatic bit id_free(logic [9:0] n);
        return free_map[n[9:5]][n[4:0]];
    endfunction

    function automatic hbid_pkg::out_word_t allocator_step(hbid_pkg::in_word_t w);
        hbid_pkg::out_word_t r;
        int                  found;
        r     = '0;
        found = -1;
        case (w.command)
            hbid_pkg::CMD_ALLOC, hbid_pkg::CMD_ALLOC_FROM: begin
                for (int i = (w.command == hbid_pkg::CMD_ALLOC) ? 0 : int'(w.id); i < 1024;
                     i++) begin
                    if (found < 0 && id_free(10'(i))) begin
                        found = i;
                    end
                end
                if (found < 0) begin
                    r.status = hbid_pkg::ST_NO_SPACE;
                end else begin
                    free_map[found >> 5][found & 31] = 1'b0;
                    id_value[found] = w.value;
                    r.result_id = 10'(found);
                end
            end
            hbid_pkg::CMD_FREE: begin
                if (id_free(w.id)) begin
                    r.status = hbid_pkg::ST_NOT_ALLOC;
                end else begin
                    free_map[w.id[9:5]][w.id[4:0]] = 1'b1;
                    id_value[w.id] = '0;
                end
            end
            hbid_pkg::CMD_LOOKUP: begin
                if (!id_free(w.id)) begin
                    r.result_value = id_value[w.id];
                end
            end
            hbid_pkg::CMD_REPLACE: begin
                if (id_free(w.id)) begin
                    r.status = hbid_pkg::ST_NOT_ALLOC;
                end else begin
                    r.result_value = id_value[w.id];
                    id_value[w.id] = w.value;
                end
            end
            hbid_pkg::CMD_CLEAR: clear_allocator();
            default: ;
        endcase
        return r;
    endfunction

    function automatic int random_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [63:0] random_value();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_word(hbid_pkg::in_word_t w, bit known, hbid_pkg::out_word_t want);
        hbid_pkg::out_word_t predicted;
        int                  gap;
        gap = random_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data  <= w;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        predicted = allocator_step(w);
        ops_seen[w.command]++;
        if (known && predicted !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("table row cmd %0d id %0d: exp st %0d id %0d val %h, pred st %0d id %0d val %h",
                         w.command, w.id, want.status, want.result_id, want.result_value,
                         predicted.status, predicted.result_id, predicted.result_value);
        end
        pending_results.push_back(predicted);
    endtask

    // result side: random stalls, compare against the oldest prediction
    initial begin
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result word %h", m_data);
                end else begin
                    hbid_pkg::out_word_t want;
                    want = pending_results.pop_front();
                    result_count++;
                    if (m_data.status !== want.status || m_data.result_id !== want.result_id
                        || m_data.result_value !== want.result_value) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: exp st %0d id %0d val %h, got st %0d id %0d val %h",
                                     want.status, want.result_id, want.result_value,
                                     m_data.status, m_data.result_id, m_data.result_value);
                    end
                end
            end
            m_ready <= ($urandom_range(0, 99) < 8) ? 1'b0 : ($urandom_range(0, 3) != 0);
        end
    end

    // watchdog: cycles with no word moving on either side
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired");
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        stim_row_t           stim_table [$];
        hbid_pkg::in_word_t  w;
        hbid_pkg::out_word_t want;
        int                  n_ok;
        int                  held [$];
        int                  pick;

        s_valid = 1'b0;
        s_data  = '0;
        aresetn = 1'b0;
        mismatch_count = 0;
        result_count   = 0;
        foreach (ops_seen[i]) ops_seen[i] = 0;
        clear_allocator();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows; known = 1 where the answer is plain from the rules
        stim_table = '{
            '{hbid_pkg::CMD_LOOKUP,     10'd0,    64'h0,  1'b1, hbid_pkg::ST_OK,
              10'd0,    64'h0},
            '{hbid_pkg::CMD_FREE,       10'd5,    64'h0,  1'b1, hbid_pkg::ST_NOT_ALLOC,
              10'd0,    64'h0},
            '{hbid_pkg::CMD_REPLACE,    10'd1023, 64'h1,  1'b1, hbid_pkg::ST_NOT_ALLOC,
              10'd0,    64'h0},
            '{hbid_pkg::CMD_ALLOC,      10'd77,   '1,     1'b1, hbid_pkg::ST_OK,
              10'd0,    64'h0},
            '{hbid_pkg::CMD_ALLOC,      10'd0,    64'h0,  1'b1, hbid_pkg::ST_OK,
              10'd1,    64'h0},
            '{hbid_pkg::CMD_ALLOC_FROM, 10'd1023, 64'hA5, 1'b1, hbid_pkg::ST_OK,
              10'd1023, 64'h0},
            '{hbid_pkg::CMD_ALLOC_FROM, 10'd1023, 64'h1,  1'b1, hbid_pkg::ST_NO_SPACE,
              10'd0,    64'h0},
            '{hbid_pkg::CMD_LOOKUP,     10'd0,    64'h0,  1'b1, hbid_pkg::ST_OK,
              10'd0,    '1},
            '{hbid_pkg::CMD_REPLACE,    10'd1023, 64'h5A, 1'b1, hbid_pkg::ST_OK,
              10'd0,    64'hA5},
            '{hbid_pkg::CMD_ALLOC_FROM, 10'd31,   64'h3,  1'b0, hbid_pkg::ST_OK,
              10'd0,    64'h0},
            '{hbid_pkg::CMD_ALLOC_FROM, 10'd32,   64'h4,  1'b0, hbid_pkg::ST_OK,
              10'd0,    64'h0},
            '{hbid_pkg::CMD_FREE,       10'd0,    64'h0,  1'b1, hbid_pkg::ST_OK,
              10'd0,    64'h0},
            '{hbid_pkg::CMD_LOOKUP,     10'd0,    64'h0,  1'b1, hbid_pkg::ST_OK,
              10'd0,    64'h0},
            '{hbid_pkg::CMD_ALLOC,      10'd0,    64'h9,  1'b1, hbid_pkg::ST_OK,
              10'd0,    64'h0},
            '{3'd6,                     10'd1,    '1,     1'b1, hbid_pkg::ST_OK,
              10'd0,    64'h0},
            '{3'd7,                     '1,       '1,     1'b1, hbid_pkg::ST_OK,
              10'd0,    64'h0},
            '{hbid_pkg::CMD_CLEAR,      10'd0,    64'h0,  1'b1, hbid_pkg::ST_OK,
              10'd0,    64'h0},
            '{hbid_pkg::CMD_LOOKUP,     10'd1023, 64'h0,  1'b1, hbid_pkg::ST_OK,
              10'd0,    64'h0}
        };
        foreach (stim_table[i]) begin
            w.command = stim_table[i].command;
            w.id      = stim_table[i].id;
            w.value   = stim_table[i].value;
            want      = '{stim_table[i].status, stim_table[i].result_id,
                          stim_table[i].result_value};
            send_word(w, stim_table[i].known, want);
        end

        // fill the low leaves with allocations at random gaps, then allocate from the bottom once more
        for (int i = 0; i < N_FILL; i++) begin
            w = '{hbid_pkg::CMD_ALLOC, 10'($urandom), random_value()};
            send_word(w, 1'b0, '0);
        end
        w = '{hbid_pkg::CMD_ALLOC_FROM, 10'd0, 64'h0};
        send_word(w, 1'b0, '0);

        // hold the sender until every result is back
        s_valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge aclk);

        for (int i = 0; i < N_RANDOM; i++) begin
            held.delete();
            for (int k = 0; k < 1024; k++) if (!id_free(10'(k))) held.push_back(k);
            pick = $urandom_range(0, 99);
            w.value = random_value();
            w.id    = 10'($urandom);
            if (held.size() > 0 && pick < 70)
                w.id = 10'(held[$urandom_range(0, held.size() - 1)]);
            case ($urandom_range(0, 99)) inside
                [0:24]:  w.command = hbid_pkg::CMD_ALLOC;
                [25:44]: w.command = hbid_pkg::CMD_ALLOC_FROM;
                [45:69]: w.command = hbid_pkg::CMD_FREE;
                [70:82]: w.command = hbid_pkg::CMD_LOOKUP;
                [83:96]: w.command = hbid_pkg::CMD_REPLACE;
                [97:98]: w.command = 3'($urandom_range(6, 7));
                default: w.command = hbid_pkg::CMD_CLEAR;
            endcase
            send_word(w, 1'b0, '0);
        end

        s_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (20) @(posedge aclk);
        n_ok = result_count;
        $display("covered %0d results: alloc %0d, alloc-from %0d, free %0d, lookup %0d,",
                 n_ok, ops_seen[0], ops_seen[1], ops_seen[2], ops_seen[3]);
        $display("replace %0d, clear %0d, unused codes %0d", ops_seen[4], ops_seen[5],
                 ops_seen[6] + ops_seen[7]);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
